[hdl/sha1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round helpers of the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int BLOCK_BITS  = 512;
	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 5;
	localparam int LAST_ROUND  = 79;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] K_00_19 = 32'h5a827999;
	localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
	localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
	localparam logic [31:0] K_60_79 = 32'hca62c1d6;

	localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	// one 64-byte block for the compression core; last marks the final block
	typedef struct packed {
		logic                  last;
		logic [BLOCK_BITS-1:0] block;
	} job_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		if (t < 7'd20)
			round_k = K_00_19;
		else if (t < 7'd40)
			round_k = K_20_39;
		else if (t < 7'd60)
			round_k = K_40_59;
		else
			round_k = K_60_79;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		if (t < 7'd20)
			round_f = (b & c) | (~b & d);
		else if (t < 7'd40)
			round_f = b ^ c ^ d;
		else if (t < 7'd60)
			round_f = (b & c) | (b & d) | (c & d);
		else
			round_f = b ^ c ^ d;
	endfunction

endpackage

[hdl/sha1_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_front
// Packs message bytes big-endian into blocks, builds the padding blocks at
// end of message and hands each block to the job queue.
// ----------------------------------------------------------------------------
module sha1_front import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_stall,
	input  msg_item_t msg_item,
	output logic      push,
	output job_t      push_job,
	input  logic      q_full
);

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_PAD = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;

	logic [1:0]            state_q;
	logic [5:0]            cnt_q;
	logic [60:0]           len_q;
	logic [BLOCK_BITS-1:0] blk_q;

	logic                  take;
	logic [BLOCK_BITS-1:0] blk_byte;
	logic [BLOCK_BITS-1:0] pad_blk;
	logic [BLOCK_BITS-1:0] len_blk;
	logic [63:0]           len_bits;
	logic                  two_blocks;

	assign msg_stall  = (state_q != ST_ACC) || q_full;
	assign take       = msg_valid && !msg_stall;
	assign len_bits   = {len_q, 3'b000};
	assign two_blocks = cnt_q >= 6'd56;

	always_comb begin
		blk_byte = blk_q;
		pad_blk  = '0;
		for (int p = 0; p < 64; p++) begin
			if (6'(p) == cnt_q) begin
				blk_byte[BLOCK_BITS-1-8*p -: 8] = msg_item.data_byte;
				pad_blk[BLOCK_BITS-1-8*p -: 8]  = PAD_BYTE;
			end else if (6'(p) < cnt_q) begin
				pad_blk[BLOCK_BITS-1-8*p -: 8]  = blk_q[BLOCK_BITS-1-8*p -: 8];
			end
		end
		len_blk       = pad_blk;
		len_blk[63:0] = len_bits;
	end

	always_comb begin
		push           = 1'b0;
		push_job.last  = 1'b0;
		push_job.block = blk_byte;
		unique case (state_q)
			ST_ACC: begin
				push = take && msg_item.has_byte && (cnt_q == 6'd63);
			end
			ST_PAD: begin
				push = !q_full;
				if (two_blocks) begin
					push_job.block = pad_blk;
				end else begin
					push_job.last  = 1'b1;
					push_job.block = len_blk;
				end
			end
			ST_LEN: begin
				push           = !q_full;
				push_job.last  = 1'b1;
				push_job.block = {{(BLOCK_BITS-64){1'b0}}, len_bits};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
			len_q   <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (take) begin
						if (msg_item.has_byte) begin
							cnt_q <= cnt_q + 6'd1;
							len_q <= len_q + 61'd1;
						end
						if (msg_item.end_of_message)
							state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (push) begin
						if (two_blocks) begin
							state_q <= ST_LEN;
						end else begin
							state_q <= ST_ACC;
							cnt_q   <= '0;
							len_q   <= '0;
						end
					end
				end
				ST_LEN: begin
					if (push) begin
						state_q <= ST_ACC;
						cnt_q   <= '0;
						len_q   <= '0;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	// block bytes: payload only
	always_ff @(posedge clk) begin
		if (take && msg_item.has_byte)
			blk_q <= blk_byte;
	end

endmodule

[hdl/sha1_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_fifo
// Short queue of block jobs between the byte packer and the compression core.
// ----------------------------------------------------------------------------
module sha1_fifo import sha1_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	job_t          slot_q [Depth];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full       = cnt_q == CW'(Depth);
	assign head_valid = cnt_q != '0;
	assign head_job   = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_job;
	end

endmodule

[hdl/sha1_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_core
// 80-round SHA-1 compression, one round per cycle with a rolling 16-word
// schedule; sends the digest word by word after the final block.
// ----------------------------------------------------------------------------
module sha1_core import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      q_job,
	output logic      q_pop,
	output logic      dig_valid,
	input  logic      dig_stall,
	output dig_item_t dig_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RND  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [6:0]  rnd_q;
	logic        last_q;
	logic [2:0]  idx_q;
	logic [31:0] chain_q [CHAIN_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] win_q [BLOCK_WORDS];

	logic [31:0] tmp;
	logic [31:0] w_next;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign dig_valid = state_q == ST_OUT;

	assign dig_item.digest_word = chain_q[idx_q];
	assign dig_item.word_index  = idx_q;
	assign dig_item.last_word   = idx_q == 3'(CHAIN_WORDS - 1);

	assign tmp    = rotl(a_q, 5) + round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ round_k(rnd_q) + win_q[0];
	assign w_next = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			last_q  <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < CHAIN_WORDS; i++)
				chain_q[i] <= H_INIT[i];
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_RND;
						rnd_q   <= '0;
						last_q  <= q_job.last;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(LAST_ROUND))
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					idx_q      <= '0;
					state_q    <= last_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (!dig_stall) begin
						if (dig_item.last_word) begin
							// message done: back to the initial chain
							state_q <= ST_IDLE;
							for (int i = 0; i < CHAIN_WORDS; i++)
								chain_q[i] <= H_INIT[i];
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working variables and schedule window: payload only
	always_ff @(posedge clk) begin
		if (q_pop) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
			for (int i = 0; i < BLOCK_WORDS; i++)
				win_q[i] <= q_job.block[BLOCK_BITS-1-32*i -: 32];
		end else if (state_q == ST_RND) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
			// advance the window; the new tail is w[t+16]
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[BLOCK_WORDS-1] <= w_next;
		end
	end

endmodule

[hdl/sha1_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Streaming SHA-1: message bytes in, five 32-bit digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel (msg_valid / msg_stall / msg_item): one word per item, holding
//   an optional message byte and an end-of-message flag. A byte with end set
//   is absorbed before padding.
//   dig channel (dig_valid / dig_stall / dig_item): after end of message the
//   five digest words leave in order, word_index 0..4, last_word on the fifth.
// Timing:
//   bytes are taken one per cycle into the packing buffer while msg_stall
//   is low. Every 64th byte hands a block to a job queue (QueueDepth
//   entries); the core runs it as pop, 80 rounds at one per cycle, then
//   chain add. With the queue full the input stalls. After end of message,
//   padding takes one or two queue pushes; the first digest word is offered
//   once the last padding block has been through the core.
// Reset and back pressure:
//   reset clears the counters and queue and returns the chain to the
//   SHA-1 initial values. While dig_stall is high the current digest word
//   holds; input still fills the buffer and queue until they are full.
// ----------------------------------------------------------------------------
module sha1_stream_hasher import sha1_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_stall,
	input  msg_item_t msg_item,
	output logic      dig_valid,
	input  logic      dig_stall,
	output dig_item_t dig_item
);

	logic push;
	job_t push_job;
	logic q_full;
	logic q_pop;
	logic q_valid;
	job_t q_job;

	sha1_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_item  (msg_item),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	sha1_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_job)
	);

	sha1_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.q_pop     (q_pop),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig_item  (dig_item)
	);

endmodule

[verif/sha1_stream_hasher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Self-checking bench for the streaming SHA-1 hasher. A directed table covers
// known digests, ignored words and end-with-byte. Whole messages follow, at
// and around the block and padding boundaries, and then random short and
// mid-size messages. A SHA-1 model in the bench predicts the digests
// that the table does not give. Both handshake sides idle at random. Once the
// digest side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb import sha1_pkg::*; ();

	localparam int          WORD_TARGET = 310;
	localparam int          HOLD_CYCLES = 700;
	localparam int          SETTLE      = 400;
	localparam int          CYCLE_LIMIT = 300000;
	localparam int          REPORT_MAX  = 10;
	localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
	localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
	localparam logic [159:0] NO_DIGEST    = '0;

	typedef struct packed {
		msg_item_t     item;
		logic          typed;
		logic [159:0]  digest;
	} probe_row_t;

	localparam int PROBE_COUNT = 12;
	localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
		{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
		{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
		{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		{8'h5a, 1'b0, 1'b1, 1'b0, NO_DIGEST},
		{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
		{8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST}
	};

	localparam int EDGE_COUNT = 4;
	localparam int EDGE_LENGTHS [EDGE_COUNT] = '{55, 56, 64, 1};

	logic      clk;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_stall;
	msg_item_t msg_item;
	logic      dig_valid;
	logic      dig_stall;
	dig_item_t dig_item;

	// model state
	logic [31:0] chain_h [CHAIN_WORDS];
	logic [31:0] block_w [BLOCK_WORDS];
	logic [5:0]  block_fill;
	logic [60:0] msg_bytes;

	dig_item_t digest_q [$];
	int        mismatches;
	int        words_sent;
	int        send_burst;
	int        recv_burst;
	int        cycles;
	bit        hold_req;

	sha1_stream_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg_item (msg_item),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.dig_item (dig_item)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digest words pending", cycles,
				digest_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
		rotate_left = (v << s) | (v >> (32 - s));
	endfunction

	task automatic clear_chain();
		chain_h    = H_INIT;
		block_fill = '0;
		msg_bytes  = '0;
		for (int i = 0; i < BLOCK_WORDS; i++)
			block_w[i] = '0;
	endtask

	task automatic compress_chain();
		logic [31:0] sched [BLOCK_WORDS];
		logic [31:0] a, b, c, d, e, f, k, t;
		int          j;
		sched = block_w;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			j = r % 16;
			if (r >= 16)
				sched[j] = rotate_left(sched[(j + 13) % 16] ^ sched[(j + 8) % 16] ^
					sched[(j + 2) % 16] ^ sched[j], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_00_19;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_20_39;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_40_59;
			end else begin
				f = b ^ c ^ d;
				k = K_60_79;
			end
			t = rotate_left(a, 5) + f + e + k + sched[j];
			e = d;
			d = c;
			c = rotate_left(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	// big-endian byte lane inside the block; lane 0 starts a fresh word
	task automatic place_byte(input int pos, input logic [7:0] v);
		int wi;
		int sh;
		wi = pos / 4;
		sh = 24 - 8 * (pos % 4);
		if (pos % 4 == 0)
			block_w[wi] = '0;
		block_w[wi] |= 32'(v) << sh;
	endtask

	// advance the model by one accepted word; queue the digest on end of message
	task automatic absorb_word(input msg_item_t it, input logic typed,
		input logic [159:0] known);
		logic [63:0] bit_len;
		dig_item_t   r;
		if (it.has_byte) begin
			place_byte(int'(block_fill), it.data_byte);
			msg_bytes  = msg_bytes + 61'd1;
			block_fill = block_fill + 6'd1;
			if (block_fill == 6'd0)
				compress_chain();
		end
		if (it.end_of_message) begin
			bit_len = {msg_bytes, 3'b000};
			place_byte(int'(block_fill), PAD_BYTE);
			for (int i = int'(block_fill) + 1; i < 64; i++)
				place_byte(i, 8'h00);
			// no room for the length: flush and start a zero block
			if (block_fill >= 6'd56) begin
				compress_chain();
				for (int i = 0; i < 14; i++)
					block_w[i] = '0;
			end
			block_w[14] = bit_len[63:32];
			block_w[15] = bit_len[31:0];
			compress_chain();
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				r.digest_word = typed ? known[159 - 32 * i -: 32] : chain_h[i];
				r.word_index  = 3'(i);
				r.last_word   = (i == CHAIN_WORDS - 1);
				digest_q.push_back(r);
			end
			clear_chain();
		end
	endtask

	task automatic check_digest(input dig_item_t got);
		dig_item_t want;
		if (digest_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("unexpected digest word %h idx %0d last %b", got.digest_word,
					got.word_index, got.last_word);
		end else begin
			want = digest_q.pop_front();
			if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
				got.last_word !== want.last_word) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"digest word mismatch: expected %h idx %0d last %b, ",
						"got %h idx %0d last %b"},
						want.digest_word, want.word_index, want.last_word,
						got.digest_word, got.word_index, got.last_word);
			end
		end
	endtask

	task automatic send_word(input msg_item_t it, input logic typed, input logic [159:0] known);
		int gap;
		if (send_burst > 0) begin
			gap = 0;
			send_burst--;
		end else if ($urandom_range(0, 7) == 0) begin
			gap = 0;
			send_burst = $urandom_range(8, 40);
		end else begin
			gap = $urandom_range(0, 12);
		end
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg_item  <= it;
		do @(negedge clk); while (msg_stall);
		@(posedge clk);
		absorb_word(it, typed, known);
		words_sent++;
	endtask

	// random bytes, stray empty words, end either on the last byte or on its own
	task automatic send_message(input int len);
		msg_item_t it;
		bit        end_on_byte;
		end_on_byte = $urandom_range(0, 1);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				it.data_byte      = 8'($urandom);
				it.has_byte       = 1'b0;
				it.end_of_message = 1'b0;
				send_word(it, 1'b0, NO_DIGEST);
			end
			it.data_byte      = 8'($urandom);
			it.has_byte       = 1'b1;
			it.end_of_message = end_on_byte && (n == len - 1);
			send_word(it, 1'b0, NO_DIGEST);
		end
		if (!end_on_byte || len == 0) begin
			it.data_byte      = 8'($urandom);
			it.has_byte       = 1'b0;
			it.end_of_message = 1'b1;
			send_word(it, 1'b0, NO_DIGEST);
		end
	endtask

	// drop valid and hold until every predicted digest word has left
	task automatic wait_drained();
		msg_valid <= 1'b0;
		do @(posedge clk); while (digest_q.size() != 0);
	endtask

	initial begin
		int len;
		cycles     = 0;
		mismatches = 0;
		words_sent = 0;
		send_burst = 0;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		msg_valid  = 1'b0;
		msg_item   = '0;
		clear_chain();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < PROBE_COUNT; n++)
			send_word(PROBE_ROWS[n].item, PROBE_ROWS[n].typed, PROBE_ROWS[n].digest);
		wait_drained();

		for (int n = 0; n < EDGE_COUNT; n++)
			send_message(EDGE_LENGTHS[n]);
		wait_drained();

		hold_req = 1'b1;
		while (words_sent < WORD_TARGET) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
			if (len > WORD_TARGET - words_sent)
				len = WORD_TARGET - words_sent;
			send_message(len);
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int        w;
		dig_item_t got;
		recv_burst = 0;
		dig_stall  = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// back up the digest side long enough to fill the input path
				dig_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (recv_burst > 0) begin
					w = 0;
					recv_burst--;
				end else if ($urandom_range(0, 7) == 0) begin
					w = 0;
					recv_burst = $urandom_range(8, 40);
				end else begin
					w = $urandom_range(0, 12);
				end
				if (w > 0) begin
					dig_stall <= 1'b1;
					repeat (w) @(posedge clk);
				end
				dig_stall <= 1'b0;
				do @(negedge clk); while (!dig_valid && !hold_req);
				if (dig_valid) begin
					got = dig_item;
					@(posedge clk);
					check_digest(got);
				end else begin
					@(posedge clk);
				end
			end
		end
	end

endmodule

[files.f]
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_fifo.sv
hdl/sha1_core.sv
hdl/sha1_stream_hasher.sv
verif/sha1_stream_hasher_tb.sv
